@@ rtl/tzps_pkg.sv @@
// Shared widths, types and edge codes for the triangle Z-plane slice unit.
package tzps_pkg;

  localparam int CoordW  = 32;                  // coordinate width
  localparam int DiffW   = CoordW + 1;          // signed difference / magnitude width
  localparam int LoW     = (DiffW + 1) / 2;     // low half of split multiplier operand
  localparam int HiW     = DiffW - LoW;         // high half
  localparam int ProdW   = 2 * DiffW;           // full magnitude product
  localparam int DivSteps = DiffW;              // quotient bits, one per stage

  localparam logic [1:0] EdgeAB = 2'd0;
  localparam logic [1:0] EdgeBC = 2'd1;
  localparam logic [1:0] EdgeCA = 2'd2;

  // Per-edge data that rides alongside the arithmetic.
  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] pa_x;
    logic [CoordW-1:0] pa_y;
    logic              neg_x;
    logic              neg_y;
    logic [1:0]        edge_num;
    logic              last;
  } side_t;

endpackage

@@ rtl/tzps_divider.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module tzps_divider
  import tzps_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [DiffW-1:0] divisor_i,
  output logic [DiffW-1:0] quotient_o
);

  // Caller guarantees quotient fits DiffW bits, so the top half starts below the divisor.
  logic [DiffW-1:0] rem_q [DivSteps];
  logic [DiffW-1:0] low_q [DivSteps];
  logic [DiffW-1:0] quo_q [DivSteps];
  logic [DiffW-1:0] div_q [DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic [DiffW-1:0] rem_in, low_in, quo_in, div_in;
    logic [DiffW:0]   trial;
    logic [DiffW:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = dividend_i[ProdW-1:DiffW];
      assign low_in = dividend_i[DiffW-1:0];
      assign quo_in = '0;
      assign div_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign div_in = div_q[s-1];
    end

    assign trial = {rem_in, low_in[DiffW-1]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = trial >= {1'b0, div_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[DiffW-1:0] : trial[DiffW-1:0];
        low_q[s] <= {low_in[DiffW-2:0], 1'b0};
        quo_q[s] <= {quo_in[DiffW-2:0], ge};
        div_q[s] <= div_in;
      end
    end
  end

  assign quotient_o = quo_q[DivSteps-1];

endmodule

@@ rtl/triangle_z_plane_slice_unit.sv @@
// Top level of the triangle Z-plane slice unit.
//
// Takes one triangle (three XYZ vertices, signed Q24.8) and emits, for edges
// a-b, b-c, c-a in order, the XY point where each edge meets the plane
// Z = slice_z. Flat edges and edges fully on one side are skipped; a vertex
// on the plane yields a hit on each of its non-flat edges. last_hit marks the
// final item of a triangle; a triangle with no crossing yields nothing.
// Rate: one edge item enters the pipeline per cycle unless the output stalls;
// a triangle holds the input until its hits, 3 at most, have entered. From
// the edge leaving the input register to the output register there are 4 stages
// of difference, magnitude, split multiply and product sum, 33 divider
// stages (one quotient bit each), and the final add. A stall on the output
// freezes the whole pipeline; nothing is lost or repeated. slice_z is
// written through the cfg channel, always ready; write it only when idle.
module triangle_z_plane_slice_unit
  import tzps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [CoordW-1:0] slice_z_i,
  // triangle input
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] a_z_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] b_z_i,
  input  logic signed [CoordW-1:0] c_x_i,
  input  logic signed [CoordW-1:0] c_y_i,
  input  logic signed [CoordW-1:0] c_z_i,
  // hit output
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] hit_x_o,
  output logic signed [CoordW-1:0] hit_y_o,
  output logic [1:0]               edge_number_o,
  output logic                     last_hit_o
);

  logic signed [CoordW-1:0] slice_z_q;
  logic adv;

  // ---------------- config register ----------------
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_z_q <= '0;
    end else if (cfg_valid_i) begin
      slice_z_q <= slice_z_i;
    end
  end

  // Whole pipeline moves unless the output item is held.
  assign adv = !(out_valid_o && out_stall_i);

  // ---------------- triangle register and edge serializer ----------------
  logic                     tv_q;
  logic [2:0]               sent_q;
  logic signed [CoordW-1:0] tx_q [3];
  logic signed [CoordW-1:0] ty_q [3];
  logic signed [CoordW-1:0] tz_q [3];
  logic [2:0] hit, rem, sel;
  logic       tri_free, accept, emit;
  logic [1:0] e_sel;
  logic       e_last;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      logic signed [CoordW-1:0] za, zb;
      za = tz_q[e];
      zb = tz_q[(e + 1) % 3];
      hit[e] = (za != zb) &&
               !(((za > slice_z_q) && (zb > slice_z_q)) ||
                 ((za < slice_z_q) && (zb < slice_z_q)));
    end
  end

  assign rem      = tv_q ? (hit & ~sent_q) : 3'b000;
  assign sel      = rem & (~rem + 3'd1);
  assign e_last   = (rem & ~sel) == 3'b000;
  assign emit     = adv && (rem != 3'b000);
  // Triangle slot frees when nothing is left or its last hit leaves now.
  assign tri_free = !tv_q || (rem == 3'b000) || (emit && e_last);
  assign in_stall_o = !tri_free;
  assign accept   = in_valid_i && tri_free;

  always_comb begin
    priority if (rem[0]) e_sel = EdgeAB;
    else if (rem[1])     e_sel = EdgeBC;
    else                 e_sel = EdgeCA;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q   <= 1'b0;
      sent_q <= '0;
    end else begin
      if (accept) begin
        tv_q   <= 1'b1;
        sent_q <= '0;
      end else begin
        if (tri_free) tv_q <= 1'b0;
        if (emit) sent_q <= sent_q | sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_q[0] <= a_x_i; ty_q[0] <= a_y_i; tz_q[0] <= a_z_i;
      tx_q[1] <= b_x_i; ty_q[1] <= b_y_i; tz_q[1] <= b_z_i;
      tx_q[2] <= c_x_i; ty_q[2] <= c_y_i; tz_q[2] <= c_z_i;
    end
  end

  // Edge end points
  logic signed [CoordW-1:0] pax, pay, paz, pbx, pby, pbz;
  always_comb begin
    unique case (e_sel)
      EdgeAB: begin
        pax = tx_q[0]; pay = ty_q[0]; paz = tz_q[0];
        pbx = tx_q[1]; pby = ty_q[1]; pbz = tz_q[1];
      end
      EdgeBC: begin
        pax = tx_q[1]; pay = ty_q[1]; paz = tz_q[1];
        pbx = tx_q[2]; pby = ty_q[2]; pbz = tz_q[2];
      end
      default: begin
        pax = tx_q[2]; pay = ty_q[2]; paz = tz_q[2];
        pbx = tx_q[0]; pby = ty_q[0]; pbz = tz_q[0];
      end
    endcase
  end

  // ---------------- stage A: differences ----------------
  logic signed [DiffW-1:0] a_dx_q, a_dy_q, a_dz_q, a_num_q;
  side_t                   a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q <= '0;
    end else if (adv) begin
      a_side_q.valid    <= emit;
      a_side_q.pa_x     <= pax;
      a_side_q.pa_y     <= pay;
      a_side_q.neg_x    <= 1'b0;
      a_side_q.neg_y    <= 1'b0;
      a_side_q.edge_num <= e_sel;
      a_side_q.last     <= e_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_dx_q  <= {pbx[CoordW-1], pbx} - {pax[CoordW-1], pax};
      a_dy_q  <= {pby[CoordW-1], pby} - {pay[CoordW-1], pay};
      a_dz_q  <= {pbz[CoordW-1], pbz} - {paz[CoordW-1], paz};
      a_num_q <= {slice_z_q[CoordW-1], slice_z_q} - {paz[CoordW-1], paz};
    end
  end

  // ---------------- stage B: magnitudes and result signs ----------------
  logic [DiffW-1:0] b_mdx_q, b_mdy_q, b_mnum_q, b_mdz_q;
  side_t            b_side_q;
  side_t            b_side_d;
  logic             sn;

  assign sn = a_num_q[DiffW-1] ^ a_dz_q[DiffW-1];
  always_comb begin
    b_side_d       = a_side_q;
    b_side_d.neg_x = (a_dx_q[DiffW-1] ^ sn) && (a_dx_q != '0) && (a_num_q != '0);
    b_side_d.neg_y = (a_dy_q[DiffW-1] ^ sn) && (a_dy_q != '0) && (a_num_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_side_q <= '0;
    end else if (adv) begin
      b_side_q <= b_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_mdx_q  <= a_dx_q[DiffW-1]  ? -a_dx_q  : a_dx_q;
      b_mdy_q  <= a_dy_q[DiffW-1]  ? -a_dy_q  : a_dy_q;
      b_mnum_q <= a_num_q[DiffW-1] ? -a_num_q : a_num_q;
      b_mdz_q  <= a_dz_q[DiffW-1]  ? -a_dz_q  : a_dz_q;
    end
  end

  // ---------------- stage C: split partial products ----------------
  logic [DiffW+LoW-1:0] c_plx_q, c_ply_q;
  logic [DiffW+HiW-1:0] c_phx_q, c_phy_q;
  logic [DiffW-1:0]     c_mdz_q;
  side_t                c_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_side_q <= '0;
    end else if (adv) begin
      c_side_q <= b_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_plx_q <= {{LoW{1'b0}}, b_mdx_q} * {{DiffW{1'b0}}, b_mnum_q[LoW-1:0]};
      c_phx_q <= {{HiW{1'b0}}, b_mdx_q} * {{DiffW{1'b0}}, b_mnum_q[DiffW-1:LoW]};
      c_ply_q <= {{LoW{1'b0}}, b_mdy_q} * {{DiffW{1'b0}}, b_mnum_q[LoW-1:0]};
      c_phy_q <= {{HiW{1'b0}}, b_mdy_q} * {{DiffW{1'b0}}, b_mnum_q[DiffW-1:LoW]};
      c_mdz_q <= b_mdz_q;
    end
  end

  // ---------------- stage D: full products ----------------
  logic [ProdW-1:0] d_px_q, d_py_q;
  logic [DiffW-1:0] d_mdz_q;
  side_t            d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_side_q <= '0;
    end else if (adv) begin
      d_side_q <= c_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_px_q  <= {{(ProdW-DiffW-LoW){1'b0}}, c_plx_q} + {c_phx_q, {LoW{1'b0}}};
      d_py_q  <= {{(ProdW-DiffW-LoW){1'b0}}, c_ply_q} + {c_phy_q, {LoW{1'b0}}};
      d_mdz_q <= c_mdz_q;
    end
  end

  // ---------------- divider stages ----------------
  // |num| <= |dz| on every hit, so quotient never exceeds |d| and fits DiffW bits.
  logic [DiffW-1:0] qx, qy;

  tzps_divider u_div_x (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (d_px_q),
    .divisor_i  (d_mdz_q),
    .quotient_o (qx)
  );

  tzps_divider u_div_y (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (d_py_q),
    .divisor_i  (d_mdz_q),
    .quotient_o (qy)
  );

  side_t dv_side_q [DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_side
    side_t src;
    if (s == 0) begin : g_first
      assign src = d_side_q;
    end else begin : g_next
      assign src = dv_side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_side_q[s] <= '0;
      end else if (adv) begin
        dv_side_q[s] <= src;
      end
    end
  end

  // ---------------- output stage: apply sign, add start point ----------------
  side_t            fin;
  logic [DiffW-1:0] sx, sy, hx_d, hy_d;
  logic             out_valid_q;
  logic [CoordW-1:0] hit_x_q, hit_y_q;
  logic [1:0]       edge_q;
  logic             last_q;

  assign fin  = dv_side_q[DivSteps-1];
  assign sx   = fin.neg_x ? -qx : qx;
  assign sy   = fin.neg_y ? -qy : qy;
  assign hx_d = {fin.pa_x[CoordW-1], fin.pa_x} + sx;
  assign hy_d = {fin.pa_y[CoordW-1], fin.pa_y} + sy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_x_q <= hx_d[CoordW-1:0];
      hit_y_q <= hy_d[CoordW-1:0];
      edge_q  <= fin.edge_num;
      last_q  <= fin.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_x_o       = hit_x_q;
  assign hit_y_o       = hit_y_q;
  assign edge_number_o = edge_q;
  assign last_hit_o    = last_q;

endmodule

@@ test/tb_triangle_z_plane_slice_unit.sv @@
// Testbench for the triangle Z-plane slice unit: random and directed triangles checked
// against a behavioral predictor.
module tb_triangle_z_plane_slice_unit
  import tzps_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 3000;  // idle cycles before giving up
  localparam int DrainCycles   = 60;    // covers the pipeline depth plus margin

  typedef logic signed [CoordW-1:0] coord_t;

  // One triangle: vertices a, b, c in order.
  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } triangle_t;

  // One crossing point as the block should emit it.
  typedef struct {
    coord_t     hx, hy;
    logic [1:0] edge_id;
    logic       last;
  } crossing_t;

  logic clk, rst_ni;
  logic cfg_valid, cfg_ready;
  coord_t slice_z;
  logic in_valid, in_stall;
  coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic out_valid, out_stall;
  coord_t hit_x, hit_y;
  logic [1:0] edge_number;
  logic last_hit;

  triangle_t triangle_q[$];     // triangles waiting to be sent
  crossing_t crossing_q[$];     // crossings waiting to come out
  longint    plane_z;           // predictor copy of slice_z
  int        errors;
  bit        hold_sender;       // pauses the driver between phases
  int        idle_cycles;

  triangle_z_plane_slice_unit uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .slice_z_i(slice_z),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z),
    .c_x_i(c_x), .c_y_i(c_y), .c_z_i(c_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_x_o(hit_x), .hit_y_o(hit_y),
    .edge_number_o(edge_number), .last_hit_o(last_hit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Point along one axis: pa + (pb - pa) * num / dz, exact product, quotient
  // truncated toward zero.
  function automatic coord_t interp_axis(longint pa, longint pb, longint num, longint dz);
    longint dp;
    logic [63:0] mdp, mnum, mdz, quo;
    logic [127:0] prod;
    bit neg;
    dp   = pb - pa;
    mdp  = dp < 0 ? -dp : dp;
    mnum = num < 0 ? -num : num;
    mdz  = dz < 0 ? -dz : dz;
    prod = {64'd0, mdp} * {64'd0, mnum};
    quo  = 64'(prod / {64'd0, mdz});
    neg  = ((dp < 0) != (num < 0)) != (dz < 0);
    if (dp == 0 || num == 0) neg = 1'b0;
    return neg ? coord_t'(pa - longint'(quo)) : coord_t'(pa + longint'(quo));
  endfunction

  // Works out every crossing of one triangle and queues it.
  task automatic predict_crossings(triangle_t t);
    longint vx[3], vy[3], vz[3];
    longint dz, ta, tb;
    int first, n, k;
    crossing_t c;
    first = crossing_q.size();
    n = 0;
    vx = '{t.ax, t.bx, t.cx};
    vy = '{t.ay, t.by, t.cy};
    vz = '{t.az, t.bz, t.cz};
    for (int e = 0; e < 3; e++) begin
      k  = (e + 1) % 3;
      dz = vz[k] - vz[e];
      ta = vz[e] - plane_z;
      tb = vz[k] - plane_z;
      if (dz == 0) continue;                               // flat edge
      if ((ta > 0 && tb > 0) || (ta < 0 && tb < 0)) continue;  // same side
      c.hx = interp_axis(vx[e], vx[k], plane_z - vz[e], dz);
      c.hy = interp_axis(vy[e], vy[k], plane_z - vz[e], dz);
      c.edge_id = e[1:0];
      c.last = 1'b0;
      crossing_q.push_back(c);
      n++;
    end
    if (n > 0) crossing_q[first + n - 1].last = 1'b1;
  endtask

  // Heights cluster around the plane so most edges cross or touch it.
  function automatic coord_t pick_z(longint zp);
    longint v;
    case ($urandom_range(0, 7))
      0, 1: v = zp;
      2:    v = zp + $urandom_range(0, 6) - 3;
      3, 4: v = zp + longint'($urandom_range(0, 4000)) - 2000;
      5:    v = coord_t'($urandom);
      6:    v = 32'sh7fffffff;
      default: v = -64'sd2147483648;
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_xy();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return coord_t'($urandom_range(0, 2000)) - 1000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic triangle_t make_tri(coord_t ax, ay, az, bx, by, bz, cx, cy, cz);
    triangle_t t;
    t.ax = ax; t.ay = ay; t.az = az;
    t.bx = bx; t.by = by; t.bz = bz;
    t.cx = cx; t.cy = cy; t.cz = cz;
    return t;
  endfunction

  // Sender: pops pending triangles, random gaps between items.
  int send_gap;
  always @(posedge clk or negedge rst_ni) begin
    triangle_t t;
    logic nxt_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
      {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= '0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_crossings(triangle_q.pop_front());
        nxt_valid = 1'b0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_gap = 0;
          5, 6, 7, 8:    send_gap = $urandom_range(1, 3);
          default:       send_gap = $urandom_range(10, 40);
        endcase
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap--;
        else if (triangle_q.size() > 0 && !hold_sender) begin
          t = triangle_q[0];
          nxt_valid = 1'b1;
          a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
          b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
          c_x <= t.cx; c_y <= t.cy; c_z <= t.cz;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: random stalls, each item compared with the oldest crossing.
  int stall_len;
  always @(posedge clk or negedge rst_ni) begin
    crossing_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_len = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          $error("unexpected item: x=%0d y=%0d edge=%0d", hit_x, hit_y, edge_number);
          errors++;
        end else begin
          want = crossing_q.pop_front();
          if (hit_x !== want.hx) begin
            $error("hit_x: expected %0d, got %0d", want.hx, hit_x); errors++;
          end
          if (hit_y !== want.hy) begin
            $error("hit_y: expected %0d, got %0d", want.hy, hit_y); errors++;
          end
          if (edge_number !== want.edge_id) begin
            $error("edge_number: expected %0d, got %0d", want.edge_id, edge_number);
            errors++;
          end
          if (last_hit !== want.last) begin
            $error("last_hit: expected %0d, got %0d", want.last, last_hit); errors++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: stall_len = $urandom_range(0, 3);
          3:       stall_len = $urandom_range(10, 40);
          default: stall_len = 0;
        endcase
        out_stall <= (stall_len > 0);
      end
    end
  end

  // Watchdog: any accepted item restarts the count.
  always @(posedge clk) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drain();
    while (triangle_q.size() > 0 || in_valid || crossing_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_plane(coord_t v);
    cfg_valid <= 1'b1;
    slice_z <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    plane_z = v;
  endtask

  initial begin
    coord_t planes[5];
    coord_t mx, mn;
    errors = 0;
    idle_cycles = 0;
    hold_sender = 1'b0;
    plane_z = 0;
    cfg_valid = 1'b0;
    slice_z = '0;
    out_stall = 1'b0;
    in_valid = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;

    // Directed triangles against the reset plane Z = 0.
    triangle_q.push_back(make_tri(0, 0, -256, 256, 512, 256, -256, 100, 256));   // two crossings
    triangle_q.push_back(make_tri(10, 20, 0, 30, 40, 256, 50, 60, -256));        // vertex on plane
    triangle_q.push_back(make_tri(1, 2, 0, 3, 4, 0, 5, 6, 0));                   // all flat
    triangle_q.push_back(make_tri(1, 2, 5, 3, 4, 6, 5, 6, 7));                   // all above
    triangle_q.push_back(make_tri(1, 2, -5, 3, 4, -6, 5, 6, -7));                // all below
    triangle_q.push_back(make_tri(1, 2, 0, 3, 4, 0, 5, 6, 100));                 // flat edge on plane
    triangle_q.push_back(make_tri(mn, mx, mn, mx, mn, mx, 0, 0, 0));             // extreme span
    triangle_q.push_back(make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn));
    triangle_q.push_back(make_tri(mn, mn, -1, mx, mx, 1, mx, mn, mx));           // rounding near zero
    triangle_q.push_back(make_tri(-7, 7, -3, 7, -7, 4, 0, 0, 1));                // truncation toward zero
    triangle_q.push_back(make_tri(mx, mx, 0, mn, mn, 0, 0, 0, 0));               // all on plane
    drain();

    // Phases: each plane height, then a burst of random triangles.
    planes = '{mx, mn, 32'sd256, -32'sd1, coord_t'($urandom)};
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        hold_sender = 1'b1;       // sender waits while the plane changes
        write_plane(planes[p - 1]);
        hold_sender = 1'b0;
      end
      if (p == 1) begin
        triangle_q.push_back(make_tri(1, 2, mx, 3, 4, mx - 1, 5, 6, mn));        // plane at the top
      end else if (p == 2) begin
        triangle_q.push_back(make_tri(1, 2, mn, 3, 4, mn + 1, 5, 6, mx));        // plane at the bottom
      end
      for (int i = 0; i < 45; i++)
        triangle_q.push_back(make_tri(pick_xy(), pick_xy(), pick_z(plane_z),
                                      pick_xy(), pick_xy(), pick_z(plane_z),
                                      pick_xy(), pick_xy(), pick_z(plane_z)));
    end
    drain();

    if (crossing_q.size() != 0) begin
      $error("%0d crossings never arrived", crossing_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
